// ----- src/jsfp_pkg.sv -----
// ============================================================================
// jsfp_pkg
// Shared types, codes and helpers for the JPEG segment field parser.
// ============================================================================
package jsfp_pkg;

    // Command codes; segment kinds use the same codes, zero meaning idle
    localparam logic [2:0] CMD_CONT = 3'd0;
    localparam logic [2:0] CMD_SOF0 = 3'd1;
    localparam logic [2:0] CMD_DHT  = 3'd2;
    localparam logic [2:0] CMD_DQT  = 3'd3;
    localparam logic [2:0] CMD_SOS  = 3'd4;
    localparam logic [2:0] CMD_SCAN = 3'd5;
    localparam logic [2:0] SEG_IDLE = 3'd0;

    // Phases shared by all length-prefixed segments
    localparam logic [4:0] PH_LEN_HI    = 5'd0;
    localparam logic [4:0] PH_LEN_LO    = 5'd1;
    // SOF0 phases
    localparam logic [4:0] PH_SOF_PREC  = 5'd2;
    localparam logic [4:0] PH_SOF_HT_HI = 5'd3;
    localparam logic [4:0] PH_SOF_HT_LO = 5'd4;
    localparam logic [4:0] PH_SOF_WD_HI = 5'd5;
    localparam logic [4:0] PH_SOF_WD_LO = 5'd6;
    localparam logic [4:0] PH_SOF_NCOMP = 5'd7;
    localparam logic [4:0] PH_SOF_CID   = 5'd8;
    localparam logic [4:0] PH_SOF_SAMP  = 5'd9;
    localparam logic [4:0] PH_SOF_QT    = 5'd10;
    // DHT / DQT phases
    localparam logic [4:0] PH_TBL_HDR   = 5'd2;
    localparam logic [4:0] PH_TBL_A     = 5'd3;
    localparam logic [4:0] PH_TBL_B     = 5'd4;
    // SOS phases
    localparam logic [4:0] PH_SOS_NCOMP = 5'd2;
    localparam logic [4:0] PH_SOS_CID   = 5'd3;
    localparam logic [4:0] PH_SOS_SEL   = 5'd4;
    localparam logic [4:0] PH_SOS_EXTRA = 5'd5;

    // Segment constants
    localparam logic [15:0] LEN_OVERHEAD = 16'd2;
    localparam logic [7:0]  HUFF_COUNTS  = 8'd16;
    localparam logic [7:0]  QUANT_VALUES = 8'd64;
    localparam logic [7:0]  BYTE_MARKER  = 8'hFF;
    localparam logic [7:0]  BYTE_STUFF   = 8'h00;
    localparam logic [7:0]  BYTE_EOI     = 8'hD9;

    // Result queue depth (room for two records per byte plus drain slack)
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        REC_PRECISION = 4'd0,
        REC_HEIGHT    = 4'd1,
        REC_WIDTH     = 4'd2,
        REC_COUNT     = 4'd3,
        REC_FRAME_CMP = 4'd4,
        REC_HUFF_HDR  = 4'd5,
        REC_HUFF_CNT  = 4'd6,
        REC_HUFF_SYM  = 4'd7,
        REC_QUANT_HDR = 4'd8,
        REC_QUANT_VAL = 4'd9,
        REC_SCAN_CMP  = 4'd10,
        REC_SCAN_XTRA = 4'd11,
        REC_DATA      = 4'd12,
        REC_END       = 4'd13,
        REC_ERROR     = 4'd14
    } rec_kind_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        rec_kind_t   rec_kind;
        logic [7:0]  ident;
        logic [3:0]  sel_high;
        logic [3:0]  sel_low;
        logic [7:0]  position;
        logic [15:0] field_value;
        logic        seg_done;
        logic        last;
    } out_item_t;

    // Build a record with seg_done and last cleared
    function automatic out_item_t mk_rec(rec_kind_t kind, logic [7:0] id,
                                         logic [3:0] sh, logic [3:0] sl,
                                         logic [7:0] pos, logic [15:0] val);
        out_item_t r;
        r.rec_kind    = kind;
        r.ident       = id;
        r.sel_high    = sh;
        r.sel_low     = sl;
        r.position    = pos;
        r.field_value = val;
        r.seg_done    = 1'b0;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/jpeg_segment_field_parser_top.sv -----
// ============================================================================
// jpeg_segment_field_parser_top
// Byte-serial parser for baseline JPEG segment bodies and scan data.
// ============================================================================
// Usage:
//   byte_* channel: one beat carries a command and one byte. A command of
//   SOF0, DHT, DQT or SOS starts that segment body (the byte is the length
//   high byte), SCAN starts entropy-coded data, CONT feeds the next byte.
//   rec_* channel: one beat carries one decoded record. A byte gives zero,
//   one or two records; the last record of a byte has last set, and the
//   record closing a segment has seg_done set.
//   Throughput: one byte per cycle while byte_ready is high; the byte is
//   decoded in one pass of logic and its records are written to a 4-entry
//   result queue. byte_ready stays high while at most two records wait, so
//   every byte finds room for its records. A stalled receiver stops the
//   byte channel once three or four records are queued; bytes that give no
//   record pass until then. Records leave at one per cycle while rec_ready
//   is high, so FF 00 pairs in scan data use two rec beats.
//   Reset clears the parser to idle and empties the queue.
// ============================================================================
module jpeg_segment_field_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  jsfp_pkg::in_item_t  byte_data,
    output logic                rec_valid,
    input  logic                rec_ready,
    output jsfp_pkg::out_item_t rec_data
);

    // Parser state
    logic [2:0]  seg_kind_reg,  seg_kind_next,  cur_kind;
    logic [4:0]  phase_reg,     phase_next,     cur_phase;
    logic [15:0] rem_len_reg,   rem_len_next,   cur_rem;
    logic [7:0]  hold_reg,      hold_next,      cur_hold;
    logic [7:0]  items_reg,     items_next,     cur_items;
    logic [7:0]  tbl_idx_reg,   tbl_idx_next,   cur_idx;
    logic [7:0]  sym_tot_reg,   sym_tot_next,   cur_sym;
    logic [7:0]  tbl_hdr_reg,   tbl_hdr_next,   cur_hdr;
    logic [15:0] comp_reg,      comp_next,      cur_comp;
    logic        mark_reg,      mark_next,      cur_mark;

    // Result queue
    jsfp_pkg::out_item_t             q_mem_reg [jsfp_pkg::QDEPTH];
    logic [jsfp_pkg::QAW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [jsfp_pkg::QAW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [jsfp_pkg::QAW:0]          count_reg,  count_next;

    logic                 take, start, active, pop, done, tbl_end;
    logic [1:0]           n_rec;
    jsfp_pkg::out_item_t  rec0, rec1;
    logic [7:0]           b;
    logic [15:0]          len_word, rem_dec;
    logic [7:0]           idx_inc, items_dec, sym_add;

    assign b     = byte_data.data_byte;
    assign take  = byte_valid && byte_ready;
    assign start = byte_data.cmd inside {[jsfp_pkg::CMD_SOF0:jsfp_pkg::CMD_SCAN]};
    assign active = take && (start ||
                    (byte_data.cmd == jsfp_pkg::CMD_CONT &&
                     seg_kind_reg != jsfp_pkg::SEG_IDLE));
    assign pop   = rec_valid && rec_ready;

    // Effective state: a start command clears everything first
    always_comb
    begin
        if (start)
        begin
            cur_kind  = byte_data.cmd;
            cur_phase = jsfp_pkg::PH_LEN_HI;
            cur_rem   = '0;
            cur_hold  = '0;
            cur_items = '0;
            cur_idx   = '0;
            cur_sym   = '0;
            cur_hdr   = '0;
            cur_comp  = '0;
            cur_mark  = 1'b0;
        end
        else
        begin
            cur_kind  = seg_kind_reg;
            cur_phase = phase_reg;
            cur_rem   = rem_len_reg;
            cur_hold  = hold_reg;
            cur_items = items_reg;
            cur_idx   = tbl_idx_reg;
            cur_sym   = sym_tot_reg;
            cur_hdr   = tbl_hdr_reg;
            cur_comp  = comp_reg;
            cur_mark  = mark_reg;
        end
    end

    assign len_word  = {cur_hold, b};
    assign rem_dec   = (cur_kind != jsfp_pkg::CMD_SOF0) ? cur_rem - 16'd1 : cur_rem;
    assign idx_inc   = cur_idx + 8'd1;
    assign items_dec = cur_items - 8'd1;
    assign sym_add   = cur_sym + b;

    // Decode one byte: next state and up to two records
    always_comb
    begin
        seg_kind_next = cur_kind;
        phase_next    = cur_phase;
        rem_len_next  = cur_rem;
        hold_next     = cur_hold;
        items_next    = cur_items;
        tbl_idx_next  = cur_idx;
        sym_tot_next  = cur_sym;
        tbl_hdr_next  = cur_hdr;
        comp_next     = cur_comp;
        mark_next     = cur_mark;
        rec0    = '0;
        rec1    = '0;
        n_rec   = 2'd0;
        done    = 1'b0;
        tbl_end = 1'b0;

        if (cur_kind == jsfp_pkg::CMD_SCAN)
        begin
            // Scan data with byte stuffing and end-of-image detection
            if (!cur_mark)
            begin
                if (b == jsfp_pkg::BYTE_MARKER)
                    mark_next = 1'b1;
                else
                begin
                    rec0  = jsfp_pkg::mk_rec(jsfp_pkg::REC_DATA, '0, '0, '0, '0, {8'd0, b});
                    n_rec = 2'd1;
                end
            end
            else if (b == jsfp_pkg::BYTE_STUFF)
            begin
                rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_DATA, '0, '0, '0, '0,
                                        {8'd0, jsfp_pkg::BYTE_MARKER});
                rec1 = jsfp_pkg::mk_rec(jsfp_pkg::REC_DATA, '0, '0, '0, '0,
                                        {8'd0, jsfp_pkg::BYTE_STUFF});
                n_rec     = 2'd2;
                mark_next = 1'b0;
            end
            else if (b == jsfp_pkg::BYTE_EOI)
            begin
                rec0  = jsfp_pkg::mk_rec(jsfp_pkg::REC_END, '0, '0, '0, '0, '0);
                n_rec = 2'd1;
                done  = 1'b1;
                mark_next     = 1'b0;
                seg_kind_next = jsfp_pkg::SEG_IDLE;
                phase_next    = jsfp_pkg::PH_LEN_HI;
            end
        end
        else if (cur_phase == jsfp_pkg::PH_LEN_HI)
        begin
            hold_next  = b;
            phase_next = jsfp_pkg::PH_LEN_LO;
        end
        else if (cur_phase == jsfp_pkg::PH_LEN_LO)
        begin
            // Length word: reject short lengths, skip empty tables
            if (len_word < jsfp_pkg::LEN_OVERHEAD)
            begin
                rec0  = jsfp_pkg::mk_rec(jsfp_pkg::REC_ERROR, {5'd0, cur_kind},
                                         '0, '0, '0, '0);
                n_rec = 2'd1;
                done  = 1'b1;
                seg_kind_next = jsfp_pkg::SEG_IDLE;
                phase_next    = jsfp_pkg::PH_LEN_HI;
            end
            else
            begin
                rem_len_next = len_word - jsfp_pkg::LEN_OVERHEAD;
                if ((cur_kind == jsfp_pkg::CMD_DHT || cur_kind == jsfp_pkg::CMD_DQT) &&
                    len_word == jsfp_pkg::LEN_OVERHEAD)
                begin
                    seg_kind_next = jsfp_pkg::SEG_IDLE;
                    phase_next    = jsfp_pkg::PH_LEN_HI;
                end
                else
                    phase_next = jsfp_pkg::PH_TBL_HDR;
            end
        end
        else if (cur_kind != jsfp_pkg::CMD_SOF0 && cur_rem == 16'd0)
        begin
            // Length overrun
            rec0  = jsfp_pkg::mk_rec(jsfp_pkg::REC_ERROR, {5'd0, cur_kind},
                                     '0, '0, '0, '0);
            n_rec = 2'd1;
            done  = 1'b1;
            seg_kind_next = jsfp_pkg::SEG_IDLE;
            phase_next    = jsfp_pkg::PH_LEN_HI;
        end
        else
        begin
            rem_len_next = rem_dec;
            case (cur_kind)
                jsfp_pkg::CMD_SOF0:
                begin
                    case (cur_phase)
                        jsfp_pkg::PH_SOF_PREC:
                        begin
                            rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_PRECISION, '0, '0, '0,
                                                    '0, {8'd0, b});
                            n_rec      = 2'd1;
                            phase_next = jsfp_pkg::PH_SOF_HT_HI;
                        end
                        jsfp_pkg::PH_SOF_HT_HI, jsfp_pkg::PH_SOF_WD_HI:
                        begin
                            hold_next  = b;
                            phase_next = cur_phase + 5'd1;
                        end
                        jsfp_pkg::PH_SOF_HT_LO, jsfp_pkg::PH_SOF_WD_LO:
                        begin
                            rec0 = jsfp_pkg::mk_rec(
                                (cur_phase == jsfp_pkg::PH_SOF_HT_LO) ?
                                    jsfp_pkg::REC_HEIGHT : jsfp_pkg::REC_WIDTH,
                                '0, '0, '0, '0, len_word);
                            n_rec      = 2'd1;
                            phase_next = cur_phase + 5'd1;
                        end
                        jsfp_pkg::PH_SOF_NCOMP:
                        begin
                            items_next   = b;
                            tbl_idx_next = '0;
                            rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_COUNT, '0, '0, '0,
                                                    '0, {8'd0, b});
                            n_rec = 2'd1;
                            if (b == 8'd0)
                            begin
                                done          = 1'b1;
                                seg_kind_next = jsfp_pkg::SEG_IDLE;
                                phase_next    = jsfp_pkg::PH_LEN_HI;
                            end
                            else
                                phase_next = jsfp_pkg::PH_SOF_CID;
                        end
                        jsfp_pkg::PH_SOF_CID:
                        begin
                            comp_next  = {b, 8'd0};
                            phase_next = jsfp_pkg::PH_SOF_SAMP;
                        end
                        jsfp_pkg::PH_SOF_SAMP:
                        begin
                            comp_next  = {cur_comp[15:8], b};
                            phase_next = jsfp_pkg::PH_SOF_QT;
                        end
                        jsfp_pkg::PH_SOF_QT:
                        begin
                            rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_FRAME_CMP,
                                                    cur_comp[15:8], cur_comp[7:4],
                                                    cur_comp[3:0], cur_idx, {8'd0, b});
                            n_rec        = 2'd1;
                            tbl_idx_next = idx_inc;
                            items_next   = items_dec;
                            if (items_dec == 8'd0)
                            begin
                                done          = 1'b1;
                                seg_kind_next = jsfp_pkg::SEG_IDLE;
                                phase_next    = jsfp_pkg::PH_LEN_HI;
                            end
                            else
                                phase_next = jsfp_pkg::PH_SOF_CID;
                        end
                        default:
                        begin
                            seg_kind_next = jsfp_pkg::SEG_IDLE;
                            phase_next    = jsfp_pkg::PH_LEN_HI;
                        end
                    endcase
                end
                jsfp_pkg::CMD_DHT:
                begin
                    if (cur_phase == jsfp_pkg::PH_TBL_HDR)
                    begin
                        tbl_hdr_next = b;
                        tbl_idx_next = '0;
                        sym_tot_next = '0;
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_HUFF_HDR, {4'd0, b[3:0]},
                                                b[7:4], '0, '0, '0);
                        n_rec      = 2'd1;
                        phase_next = jsfp_pkg::PH_TBL_A;
                    end
                    else if (cur_phase == jsfp_pkg::PH_TBL_A)
                    begin
                        // Code-length counts; symbol total wraps at 8 bits
                        sym_tot_next = sym_add;
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_HUFF_CNT,
                                                {4'd0, cur_hdr[3:0]}, cur_hdr[7:4], '0,
                                                cur_idx, {8'd0, b});
                        n_rec        = 2'd1;
                        tbl_idx_next = idx_inc;
                        if (idx_inc == jsfp_pkg::HUFF_COUNTS)
                        begin
                            tbl_idx_next = '0;
                            if (sym_add == 8'd0)
                                tbl_end = 1'b1;
                            else
                                phase_next = jsfp_pkg::PH_TBL_B;
                        end
                    end
                    else if (cur_phase == jsfp_pkg::PH_TBL_B)
                    begin
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_HUFF_SYM,
                                                {4'd0, cur_hdr[3:0]}, cur_hdr[7:4], '0,
                                                cur_idx, {8'd0, b});
                        n_rec        = 2'd1;
                        tbl_idx_next = idx_inc;
                        if (idx_inc == cur_sym)
                            tbl_end = 1'b1;
                    end
                    else
                    begin
                        seg_kind_next = jsfp_pkg::SEG_IDLE;
                        phase_next    = jsfp_pkg::PH_LEN_HI;
                    end
                end
                jsfp_pkg::CMD_DQT:
                begin
                    if (cur_phase == jsfp_pkg::PH_TBL_HDR)
                    begin
                        tbl_hdr_next = b;
                        items_next   = jsfp_pkg::QUANT_VALUES;
                        tbl_idx_next = '0;
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_QUANT_HDR, {4'd0, b[3:0]},
                                                b[7:4], '0, '0, '0);
                        n_rec      = 2'd1;
                        phase_next = jsfp_pkg::PH_TBL_A;
                    end
                    else if (cur_phase == jsfp_pkg::PH_TBL_A && cur_hdr[7:4] != 4'd0)
                    begin
                        // 16-bit value: hold the high byte
                        hold_next  = b;
                        phase_next = jsfp_pkg::PH_TBL_B;
                    end
                    else if (cur_phase == jsfp_pkg::PH_TBL_A ||
                             cur_phase == jsfp_pkg::PH_TBL_B)
                    begin
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_QUANT_VAL,
                                                {4'd0, cur_hdr[3:0]}, cur_hdr[7:4], '0,
                                                cur_idx,
                                                (cur_phase == jsfp_pkg::PH_TBL_B) ?
                                                    len_word : {8'd0, b});
                        n_rec        = 2'd1;
                        tbl_idx_next = idx_inc;
                        items_next   = items_dec;
                        phase_next   = jsfp_pkg::PH_TBL_A;
                        if (items_dec == 8'd0)
                            tbl_end = 1'b1;
                    end
                    else
                    begin
                        seg_kind_next = jsfp_pkg::SEG_IDLE;
                        phase_next    = jsfp_pkg::PH_LEN_HI;
                    end
                end
                default:
                begin
                    // SOS header
                    if (cur_phase == jsfp_pkg::PH_SOS_NCOMP ||
                        cur_phase == jsfp_pkg::PH_SOS_SEL)
                    begin
                        if (cur_phase == jsfp_pkg::PH_SOS_NCOMP)
                        begin
                            items_next   = b;
                            tbl_idx_next = '0;
                            rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_COUNT, '0, '0, '0,
                                                    '0, {8'd0, b});
                        end
                        else
                        begin
                            rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_SCAN_CMP,
                                                    cur_comp[7:0], b[7:4], b[3:0],
                                                    cur_idx, '0);
                            tbl_idx_next = idx_inc;
                            items_next   = items_dec;
                        end
                        n_rec = 2'd1;
                        if (items_next == 8'd0)
                        begin
                            tbl_idx_next = '0;
                            if (rem_dec == 16'd0)
                            begin
                                done          = 1'b1;
                                seg_kind_next = jsfp_pkg::SEG_IDLE;
                                phase_next    = jsfp_pkg::PH_LEN_HI;
                            end
                            else
                                phase_next = jsfp_pkg::PH_SOS_EXTRA;
                        end
                        else
                            phase_next = jsfp_pkg::PH_SOS_CID;
                    end
                    else if (cur_phase == jsfp_pkg::PH_SOS_CID)
                    begin
                        comp_next  = {8'd0, b};
                        phase_next = jsfp_pkg::PH_SOS_SEL;
                    end
                    else if (cur_phase == jsfp_pkg::PH_SOS_EXTRA)
                    begin
                        rec0 = jsfp_pkg::mk_rec(jsfp_pkg::REC_SCAN_XTRA, '0, '0, '0,
                                                cur_idx, {8'd0, b});
                        n_rec        = 2'd1;
                        tbl_idx_next = idx_inc;
                        if (rem_dec == 16'd0)
                        begin
                            done          = 1'b1;
                            seg_kind_next = jsfp_pkg::SEG_IDLE;
                            phase_next    = jsfp_pkg::PH_LEN_HI;
                        end
                    end
                    else
                    begin
                        seg_kind_next = jsfp_pkg::SEG_IDLE;
                        phase_next    = jsfp_pkg::PH_LEN_HI;
                    end
                end
            endcase

            // Table finished: close the segment or expect another table
            if (tbl_end)
            begin
                if (rem_dec == 16'd0)
                begin
                    done          = 1'b1;
                    seg_kind_next = jsfp_pkg::SEG_IDLE;
                    phase_next    = jsfp_pkg::PH_LEN_HI;
                end
                else
                    phase_next = jsfp_pkg::PH_TBL_HDR;
            end
        end

        // Mark the last record of this byte
        if (n_rec == 2'd1)
        begin
            rec0.last     = 1'b1;
            rec0.seg_done = done;
        end
        else if (n_rec == 2'd2)
        begin
            rec1.last     = 1'b1;
            rec1.seg_done = done;
        end
    end

    // Advance parser state on each decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_kind_reg <= jsfp_pkg::SEG_IDLE;
            phase_reg    <= jsfp_pkg::PH_LEN_HI;
            rem_len_reg  <= '0;
            hold_reg     <= '0;
            items_reg    <= '0;
            tbl_idx_reg  <= '0;
            sym_tot_reg  <= '0;
            tbl_hdr_reg  <= '0;
            comp_reg     <= '0;
            mark_reg     <= 1'b0;
        end
        else if (active)
        begin
            seg_kind_reg <= seg_kind_next;
            phase_reg    <= phase_next;
            rem_len_reg  <= rem_len_next;
            hold_reg     <= hold_next;
            items_reg    <= items_next;
            tbl_idx_reg  <= tbl_idx_next;
            sym_tot_reg  <= sym_tot_next;
            tbl_hdr_reg  <= tbl_hdr_next;
            comp_reg     <= comp_next;
            mark_reg     <= mark_next;
        end
    end

    // Result queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (active)
            wr_ptr_next = wr_ptr_reg + n_rec[jsfp_pkg::QAW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(jsfp_pkg::QAW-1){1'b0}}, pop};
        count_next  = count_reg + (active ? {1'b0, n_rec} : 3'd0)
                      - {{jsfp_pkg::QAW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write up to two records per byte
    always_ff @(posedge clk)
    begin
        if (active && n_rec != 2'd0)
            q_mem_reg[wr_ptr_reg] <= rec0;
        if (active && n_rec == 2'd2)
            q_mem_reg[wr_ptr_reg + 2'd1] <= rec1;
    end

    assign byte_ready = (count_reg <= 3'(jsfp_pkg::QDEPTH - 2));
    assign rec_valid  = (count_reg != 3'd0);
    assign rec_data   = q_mem_reg[rd_ptr_reg];

endmodule

// ----- src/jsfp_checker.sv -----
// ============================================================================
// jsfp_checker
// Port-level checks for the JPEG segment field parser.
// ============================================================================
module jsfp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_ready,
    input jsfp_pkg::in_item_t  byte_data,
    input logic                rec_valid,
    input logic                rec_ready,
    input jsfp_pkg::out_item_t rec_data
);

    // Hold a stalled record
    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec_data))
        else $error("stalled record changed or dropped");

    // A record that closes a segment is the last of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.seg_done |-> rec_data.last)
        else $error("seg_done without last");

    // Error and end records always close the segment
    a_err_close: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (rec_data.rec_kind == jsfp_pkg::REC_ERROR ||
                      rec_data.rec_kind == jsfp_pkg::REC_END)
        |-> rec_data.seg_done && rec_data.last && rec_data.field_value == 16'd0)
        else $error("error or end record malformed");

    // Scan data records carry one byte and never close a segment
    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.rec_kind == jsfp_pkg::REC_DATA
        |-> rec_data.field_value[15:8] == 8'd0 && !rec_data.seg_done)
        else $error("data record malformed");

endmodule

bind jpeg_segment_field_parser_top jsfp_checker u_jsfp_checker (.*);
